// ===== hdl/chs_pkg.sv =====
// Shared constants, types and helpers of the chained hash set.
`default_nettype none

package chs_pkg;

  localparam int BUCKETS     = 64;
  localparam int CHAIN_DEPTH = 8;
  localparam int KEY_W       = 31;
  localparam int CNT_W       = 7;

  localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int FILL_W  = $clog2(CHAIN_DEPTH + 1);
  localparam int SLOT_W  = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int SLOTS   = BUCKETS * CHAIN_DEPTH;
  localparam int ADDR_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int TOTAL_W = $clog2(SLOTS + 1);

  // remainder is found DIV_STEP key bits per cycle
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = (KEY_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_W    = DIV_CYC * DIV_STEP;
  localparam int DCNT_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd64;

  localparam logic [1:0] OP_SEARCH = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_DUP  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [BKT_W-1:0]   bucket_index;
    logic [FILL_W-1:0]  bucket_fill;
    logic [TOTAL_W-1:0] total_keys;
  } out_word_t;

  // classified item passed from front to back
  typedef struct packed {
    logic [1:0]       opcode;
    logic [KEY_W-1:0] key;
    logic [BKT_W-1:0] bucket;
  } chs_item_t;

  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] r;
    r = n;
    if (n == '0)
      r = CNT_W'(1);
    else if (int'(n) > BUCKETS)
      r = CNT_W'(BUCKETS);
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] key_addr(input logic [BKT_W-1:0] b,
                                                 input logic [SLOT_W-1:0] s);
    return ADDR_W'(ADDR_W'(b) * ADDR_W'(CHAIN_DEPTH) + ADDR_W'(s));
  endfunction

endpackage

`default_nettype wire

// ===== hdl/chs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we)
      mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hdl/chs_front.sv =====
// Front end: takes input words and finds the bucket by key modulo bucket count.
`default_nettype none

module chs_front
  import chs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire in_word_t         in_word,
  input  wire logic [CNT_W-1:0] divisor,
  output logic                  q_push,
  output chs_item_t             q_item,
  input  wire logic             q_full
);

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_HOLD} fstate_t;

  fstate_t           state_r;
  logic [1:0]        op_r;
  logic [KEY_W-1:0]  key_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [CNT_W-1:0]  div_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  rem_nxt;
  logic [DCNT_W-1:0] cnt_r;

  // restoring remainder, DIV_STEP dividend bits per cycle
  always_comb begin
    logic [CNT_W-1:0] r;
    logic [CNT_W:0]   t;
    r = rem_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, dvd_r[DVD_W-1-i]};
      if (t >= {1'b0, div_r})
        r = CNT_W'(t - {1'b0, div_r});
      else
        r = t[CNT_W-1:0];
    end
    rem_nxt = r;
  end

  assign in_full = (state_r != F_IDLE);
  assign q_push  = (state_r == F_HOLD) && !q_full;
  assign q_item  = '{opcode: op_r, key: key_r, bucket: BKT_W'(rem_r)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_push) begin
            op_r    <= in_word.opcode;
            key_r   <= in_word.key;
            dvd_r   <= DVD_W'(in_word.key);
            div_r   <= divisor;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          rem_r <= rem_nxt;
          dvd_r <= dvd_r << DIV_STEP;
          cnt_r <= cnt_r + DCNT_W'(1);
          if (cnt_r == DCNT_W'(DIV_CYC - 1))
            state_r <= F_HOLD;
        end
        F_HOLD: begin
          if (!q_full)
            state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/chs_queue.sv =====
// Two-entry queue between the front end and the back end.
`default_nettype none

module chs_queue
  import chs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire chs_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output chs_item_t      pop_item,
  output logic           empty
);

  chs_item_t  ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_item = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push)
      ent_r[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push)
        wr_ptr_r <= !wr_ptr_r;
      if (do_pop)
        rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/chs_back.sv =====
// Back end: walks the bucket, updates the table and holds the result word.
`default_nettype none

module chs_back
  import chs_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire chs_item_t q_item,
  input  wire logic      q_empty,
  output logic           q_pop,
  output logic           out_empty,
  input  wire logic      out_pop,
  output out_word_t      out_word
);

  typedef enum logic [1:0] {B_IDLE, B_FILL, B_WALK, B_DONE} bstate_t;

  bstate_t            state_r;
  chs_item_t          item_r;
  logic [FILL_W-1:0]  fill_r;
  logic [SLOT_W-1:0]  slot_r;
  logic               hit_r;
  logic [BUCKETS-1:0] valid_r;
  logic [TOTAL_W-1:0] total_r;
  logic               out_valid_r;
  out_word_t          out_r;

  logic [FILL_W-1:0]  fill_rdata;
  logic [FILL_W-1:0]  fill_cur;
  logic [KEY_W-1:0]   key_rdata;
  logic [ADDR_W-1:0]  key_raddr;
  logic               ins_ok;
  logic               walk_end;

  // fill counts of buckets whose valid bit is clear read as zero
  assign fill_cur = valid_r[item_r.bucket] ? fill_rdata : '0;
  assign q_pop    = (state_r == B_IDLE) && !q_empty && !out_valid_r;
  assign walk_end = ((FILL_W'(slot_r) + FILL_W'(1)) == fill_r);
  assign ins_ok   = (item_r.opcode == OP_INSERT) && !hit_r &&
                    (int'(fill_r) < CHAIN_DEPTH);

  always_comb begin
    if (state_r == B_WALK)
      key_raddr = key_addr(item_r.bucket, SLOT_W'(slot_r + SLOT_W'(1)));
    else
      key_raddr = key_addr(item_r.bucket, '0);
  end

  chs_ram #(.WIDTH(FILL_W), .DEPTH(BUCKETS)) u_fill_ram (
    .clk   (clk),
    .we    ((state_r == B_DONE) && ins_ok),
    .waddr (item_r.bucket),
    .wdata (FILL_W'(fill_r + FILL_W'(1))),
    .raddr (q_item.bucket),
    .rdata (fill_rdata)
  );

  chs_ram #(.WIDTH(KEY_W), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    ((state_r == B_DONE) && ins_ok),
    .waddr (key_addr(item_r.bucket, SLOT_W'(fill_r))),
    .wdata (item_r.key),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

  assign out_empty = !out_valid_r;
  assign out_word  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      valid_r     <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_pop && out_valid_r)
        out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (q_pop) begin
            if (q_item.opcode == OP_CLEAR) begin
              valid_r     <= '0;
              total_r     <= '0;
              out_r       <= '{status: ST_OK, bucket_index: '0,
                               bucket_fill: '0, total_keys: '0};
              out_valid_r <= 1'b1;
            end else begin
              item_r  <= q_item;
              hit_r   <= 1'b0;
              state_r <= B_FILL;
            end
          end
        end
        B_FILL: begin
          fill_r  <= fill_cur;
          slot_r  <= '0;
          state_r <= (fill_cur == '0) ? B_DONE : B_WALK;
        end
        B_WALK: begin
          if (key_rdata == item_r.key) begin
            hit_r   <= 1'b1;
            state_r <= B_DONE;
          end else if (walk_end) begin
            state_r <= B_DONE;
          end else begin
            slot_r <= slot_r + SLOT_W'(1);
          end
        end
        B_DONE: begin
          out_r.bucket_index <= item_r.bucket;
          if (ins_ok) begin
            valid_r[item_r.bucket] <= 1'b1;
            total_r                <= total_r + TOTAL_W'(1);
            out_r.status           <= ST_OK;
            out_r.bucket_fill      <= fill_r + FILL_W'(1);
            out_r.total_keys       <= total_r + TOTAL_W'(1);
          end else begin
            out_r.bucket_fill <= fill_r;
            out_r.total_keys  <= total_r;
            if (item_r.opcode == OP_INSERT)
              out_r.status <= hit_r ? ST_DUP : ST_FULL;
            else
              out_r.status <= hit_r ? ST_OK : ST_MISS;
          end
          out_valid_r <= 1'b1;
          state_r     <= B_IDLE;
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/chained_hash_set.sv =====
// Set of keys in buckets of bounded depth, hashed by key modulo bucket count.
// Input queue side: a word (opcode, key) is taken when in_push is high and
// in_full is low. Opcodes: search, insert, clear whole table; the fourth acts as search.
// Result queue side: the oldest result word sits on out_word while out_empty
// is low and is taken when out_pop is high. One result per input word.
// cfg_valid/cfg_ready/cfg_data write the bucket count; cfg_ready is always
// high. Write it only while no word is in flight.
// The pace is set by the front end's remainder unit (4 key bits per cycle),
// which takes no new word until the last one is handed to the queue; the
// back end walks the keys of the bucket one by one and sets the pace when
// buckets are deep.
// A stalled result stops the back end after one result; the front end and
// the two-entry queue keep accepting until the queue fills.
// Reset (rst_n low, synchronous) empties the table, the queue and the result
// register and sets the bucket count to 64. Key memory needs no clearing.
`default_nettype none

module chained_hash_set
  import chs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  output logic                  in_full,
  input  wire in_word_t         in_word,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output out_word_t             out_word,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CNT_W-1:0] cfg_data
);

  logic [CNT_W-1:0] count_r;
  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  chs_item_t        q_wr_item;
  chs_item_t        q_rd_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n)
      count_r <= CNT_RESET;
    else if (cfg_valid)
      count_r <= cfg_data;
  end

  chs_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .divisor (eff_count(count_r)),
    .q_push  (q_push),
    .q_item  (q_wr_item),
    .q_full  (q_full)
  );

  chs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_wr_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_rd_item),
    .empty     (q_empty)
  );

  chs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_rd_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

// ===== tb/tb_chained_hash_set.sv =====
// Self-checking testbench of the chained hash set: directed, configuration and random tests.
`default_nettype none

module tb_chained_hash_set
  import chs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_SPARE = 2'd3;  // unused opcode, behaves as a search
  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam int SETTLE_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  logic in_full;
  in_word_t in_word = '0;
  logic out_empty;
  logic out_pop = 1'b0;
  out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = CNT_RESET;

  // mirror of the table, updated as each word is accepted
  logic [KEY_W-1:0] mirror_keys [BUCKETS][CHAIN_DEPTH];
  int mirror_fill [BUCKETS];
  int mirror_total = 0;
  logic [CNT_W-1:0] mirror_count = CNT_RESET;

  out_word_t pending_outcomes [$];
  logic [KEY_W-1:0] inserted_keys [$];
  int errors = 0;
  bit steady_feed = 1'b0;
  int pop_hold = 0;
  int pop_run = 0;

  chained_hash_set u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int divisor_now();
    int d;
    d = int'(mirror_count);
    if (d == 0)
      d = 1;
    else if (d > BUCKETS)
      d = BUCKETS;
    return d;
  endfunction

  function automatic out_word_t hash_set_outcome(input in_word_t w);
    out_word_t r;
    int b;
    bit hit;
    r = '0;
    if (w.opcode == OP_CLEAR) begin
      foreach (mirror_fill[i])
        mirror_fill[i] = 0;
      mirror_total = 0;
      r.status = ST_OK;
      return r;
    end
    b = int'(longint'(w.key) % longint'(divisor_now()));
    hit = 1'b0;
    for (int s = 0; s < mirror_fill[b]; s++)
      if (mirror_keys[b][s] == w.key)
        hit = 1'b1;
    if (w.opcode == OP_INSERT) begin
      // duplicate wins over full
      if (hit) begin
        r.status = ST_DUP;
      end else if (mirror_fill[b] >= CHAIN_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        mirror_keys[b][mirror_fill[b]] = w.key;
        mirror_fill[b]++;
        mirror_total++;
        r.status = ST_OK;
      end
    end else begin
      r.status = hit ? ST_OK : ST_MISS;
    end
    r.bucket_index = BKT_W'(b);
    r.bucket_fill  = FILL_W'(mirror_fill[b]);
    r.total_keys   = TOTAL_W'(mirror_total);
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] key_in_bucket(input int b);
    longint span;
    longint m;
    int d;
    d = divisor_now();
    span = (longint'(KEY_MAX) - b) / d;
    m = longint'($urandom_range(0, int'(span)));
    return KEY_W'(b + m * d);
  endfunction

  function automatic logic [KEY_W-1:0] any_key();
    return KEY_W'($urandom);
  endfunction

  task automatic send_word(input logic [1:0] op, input logic [KEY_W-1:0] k);
    in_word_t w;
    int gap;
    w.opcode = op;
    w.key = k;
    gap = steady_feed ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_push <= 1'b0;
    end
    @(negedge clk);
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
    pending_outcomes.push_back(hash_set_outcome(w));
    if (op == OP_INSERT) begin
      inserted_keys.push_back(k);
      if (inserted_keys.size() > 64)
        void'(inserted_keys.pop_front());
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_outcomes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [CNT_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    mirror_count = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_basic_ops();
    send_word(OP_SEARCH, '0);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, '0);
    send_word(OP_SEARCH, '0);
    send_word(OP_INSERT, KEY_MAX);
    send_word(OP_SEARCH, KEY_MAX);
    send_word(OP_SPARE, '0);
    send_word(OP_SPARE, KEY_W'(5));
    send_word(OP_SEARCH, KEY_W'(5));
  endtask

  task automatic test_full_bucket();
    logic [KEY_W-1:0] first;
    first = key_in_bucket(3);
    send_word(OP_INSERT, first);
    for (int i = 1; i < CHAIN_DEPTH; i++)
      send_word(OP_INSERT, key_in_bucket(3));
    send_word(OP_INSERT, KEY_W'(3));
    send_word(OP_INSERT, first);
    send_word(OP_SEARCH, first);
    send_word(OP_CLEAR, key_in_bucket(3));
    send_word(OP_SEARCH, first);
  endtask

  // count zero, one, above the bucket range and in between
  task automatic test_count_extremes();
    logic [CNT_W-1:0] settings [6] = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd2, 7'd64};
    foreach (settings[i]) begin
      write_count(settings[i]);
      send_word(OP_CLEAR, any_key());
      for (int n = 0; n < CHAIN_DEPTH + 2; n++)
        send_word(OP_INSERT, key_in_bucket($urandom_range(0, divisor_now() - 1) % 2));
      send_word(OP_SEARCH, inserted_keys[inserted_keys.size() - 1]);
    end
  endtask

  // keys stay where the old divisor put them
  task automatic test_stale_divisor();
    logic [KEY_W-1:0] held [10];
    write_count(7'd64);
    send_word(OP_CLEAR, '0);
    foreach (held[i]) begin
      held[i] = key_in_bucket($urandom_range(0, 63));
      send_word(OP_INSERT, held[i]);
    end
    write_count(7'd7);
    foreach (held[i])
      send_word(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_SEARCH, held[i]);
  endtask

  task automatic test_fill_table();
    longint k;
    write_count(7'd64);
    send_word(OP_CLEAR, '0);
    steady_feed = ($urandom_range(0, 1) != 0);
    for (int s = 0; s < CHAIN_DEPTH; s++)
      for (int b = 0; b < BUCKETS; b++) begin
        k = b + 64 * (s + 8 * longint'($urandom_range(0, 4194303)));
        send_word(OP_INSERT, KEY_W'(k));
      end
    steady_feed = 1'b0;
    for (int i = 0; i < 6; i++)
      send_word(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_SEARCH, any_key());
    send_word(OP_INSERT, inserted_keys[$urandom_range(0, inserted_keys.size() - 1)]);
  endtask

  task automatic test_random_mix(input int phases, input int per_phase);
    int hot [3];
    int r;
    logic [1:0] op;
    logic [KEY_W-1:0] k;
    for (int p = 0; p < phases; p++) begin
      case (p)
        0: write_count(7'd0);
        1: write_count(7'd127);
        2: write_count(7'd1);
        3: write_count(7'd64);
        default: write_count(CNT_W'($urandom_range(1, 127)));
      endcase
      if ($urandom_range(0, 1) != 0)
        send_word(OP_CLEAR, any_key());
      steady_feed = ($urandom_range(0, 3) == 0);
      foreach (hot[i])
        hot[i] = $urandom_range(0, divisor_now() - 1);
      for (int n = 0; n < per_phase; n++) begin
        r = $urandom_range(0, 99);
        if (r < 50)
          op = OP_INSERT;
        else if (r < 88)
          op = OP_SEARCH;
        else if (r < 91)
          op = OP_CLEAR;
        else
          op = OP_SPARE;
        r = $urandom_range(0, 99);
        if (r < 35 && inserted_keys.size() != 0)
          k = inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        else if (r < 75)
          k = key_in_bucket(hot[$urandom_range(0, 2)]);
        else
          k = any_key();
        send_word(op, k);
      end
      steady_feed = 1'b0;
    end
  endtask

  // result side: stalls of random length between stretches of steady popping
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      out_pop <= 1'b1;
      if (pop_run > 0)
        pop_run <= pop_run - 1;
      else if ($urandom_range(0, 1) != 0)
        pop_run <= $urandom_range(4, 60);
      else
        pop_hold <= pick_gap();
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (pending_outcomes.size() == 0) begin
        $error("result word with nothing pending: %h", out_word);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_word.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_word.status);
          errors++;
        end
        if (out_word.bucket_index !== want.bucket_index) begin
          $error("bucket_index: expected %0d, actual %0d",
                 want.bucket_index, out_word.bucket_index);
          errors++;
        end
        if (out_word.bucket_fill !== want.bucket_fill) begin
          $error("bucket_fill: expected %0d, actual %0d",
                 want.bucket_fill, out_word.bucket_fill);
          errors++;
        end
        if (out_word.total_keys !== want.total_keys) begin
          $error("total_keys: expected %0d, actual %0d",
                 want.total_keys, out_word.total_keys);
          errors++;
        end
      end
    end
  end

  initial begin
    foreach (mirror_fill[i])
      mirror_fill[i] = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_basic_ops();
    test_full_bucket();
    test_count_extremes();
    test_stale_divisor();
    test_fill_table();
    test_random_mix(12, 100);
    drain();
    if (errors == 0)
      $display("tb_chained_hash_set: PASS");
    else
      $display("tb_chained_hash_set: FAIL");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_chained_hash_set: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
